// ----- src/assert_macros.svh -----
// assertion helpers, clocked on clk and disabled while rst is high
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CHK_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define CHK_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define CHK_ALWAYS(lbl, expr, msg)
`define CHK_IMPLY(lbl, ante, cons, msg)
`endif
`endif

// ----- src/mabh_pkg.sv -----
package mabh_pkg;

  localparam int ADDR_W     = 32;
  localparam int MB_SHIFT   = 20;
  localparam int EPOCH_W    = 24;
  localparam int BIN_SZ_W   = 11;
  localparam int CFG_W      = 24;
  localparam int CFG_IDX_W  = 1;
  localparam int OUT_BIN_W  = 6;
  localparam int OUT_CNT_W  = 24;
  localparam int OUT_DATA_W = 56;
  localparam int DIV_STEP   = 4;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [EPOCH_W-1:0]  EPOCH_RESET  = 24'd100;
  localparam logic [BIN_SZ_W-1:0] BIN_SZ_RESET = 11'd16;

  localparam logic [CFG_IDX_W-1:0] CFG_EPOCH_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIN_SIZE_MB  = 1'b1;

  // work handed from the front to the back
  typedef struct packed {
    logic report;  // walk and clear the histograms first
    logic count;   // bump one bin afterwards
    logic kernel;  // which histogram gets the bump
  } cmd_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_WALK_RD,
    B_WALK_EV,
    B_WALK_END,
    B_CNT_RD,
    B_CNT_WR
  } back_state_t;

endpackage

// ----- src/mabh_queue.sv -----
module mabh_queue #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push_valid,
  output logic                         push_ready,
  input  logic [WIDTH-1:0]             push_data,
  output logic                         pop_valid,
  input  logic                         pop,
  output logic [WIDTH-1:0]             pop_data,
  output logic [$clog2(DEPTH+1)-1:0]   level
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LVL_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [LVL_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != LVL_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];
  assign level      = count;
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// ----- src/mabh_front.sv -----
module mabh_front #(
  parameter int MAX_BINS   = 64,
  parameter int TRACKED_MB = 1024
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         cfg_we,
  input  logic [mabh_pkg::CFG_IDX_W-1:0]               cfg_index,
  input  logic [mabh_pkg::CFG_W-1:0]                   cfg_data,
  input  logic                                         enable,
  input  logic                                         s_tvalid,
  output logic                                         s_tready,
  input  logic [mabh_pkg::ADDR_W-1:0]                  s_tdata,
  input  logic                                         s_tuser,
  output logic                                         cmd_valid,
  input  logic                                         cmd_ready,
  output mabh_pkg::cmd_t                               cmd,
  output logic [((MAX_BINS > 1) ? $clog2(MAX_BINS) : 1)-1:0] cmd_bin
);

  import mabh_pkg::*;

  localparam int BIN_W  = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int MIB_W  = (TRACKED_MB > 1) ? $clog2(TRACKED_MB) : 1;
  localparam int ITERS  = (MIB_W + DIV_STEP - 1) / DIV_STEP;
  localparam int DVD_W  = ITERS * DIV_STEP;
  localparam int ITER_W = (ITERS > 1) ? $clog2(ITERS) : 1;
  localparam int TRK_W  = ADDR_W - MB_SHIFT + 1;

  front_state_t          state;
  front_state_t          state_next;
  logic [EPOCH_W-1:0]    epoch_length;
  logic [BIN_SZ_W-1:0]   bin_size_mb;
  logic [EPOCH_W-1:0]    epoch_pos;
  logic [EPOCH_W-1:0]    epoch_pos_next;
  logic [EPOCH_W-1:0]    len_eff;
  logic [EPOCH_W:0]      pos_inc;
  logic [BIN_SZ_W-1:0]   divisor;
  logic                  report;
  logic                  kernel;
  logic                  tracked;
  logic                  tracked_in;
  logic [DVD_W-1:0]      dvd;
  logic [DVD_W-1:0]      dvd_next;
  logic [DVD_W-1:0]      quo;
  logic [DVD_W-1:0]      quo_next;
  logic [BIN_SZ_W-1:0]   rem;
  logic [BIN_SZ_W-1:0]   rem_next;
  logic [ITER_W-1:0]     iter;
  logic [DVD_W+BIN_W-1:0] quo_ext;
  logic                  accept;

  assign accept = s_tvalid && s_tready;

  // epoch step, zero length behaves as one
  assign len_eff        = (epoch_length == '0) ? EPOCH_W'(1) : epoch_length;
  assign pos_inc        = {1'b0, epoch_pos} + 1'b1;
  assign epoch_pos_next = (pos_inc >= {1'b0, len_eff}) ? '0 : pos_inc[EPOCH_W-1:0];

  assign tracked_in = TRK_W'(s_tdata[ADDR_W-1:MB_SHIFT]) < TRK_W'(TRACKED_MB);
  assign divisor    = (bin_size_mb == '0) ? BIN_SZ_W'(1) : bin_size_mb;

  // restoring divide, DIV_STEP quotient bits a cycle
  always_comb begin
    logic [BIN_SZ_W-1:0] r;
    logic [DVD_W-1:0]    d;
    logic [DVD_W-1:0]    q;
    logic [BIN_SZ_W:0]   t;
    r = rem;
    d = dvd;
    q = quo;
    t = '0;
    for (int i = 0; i < DIV_STEP; i++) begin
      t = {r, d[DVD_W-1]};
      d = d << 1;
      if (t >= {1'b0, divisor}) begin
        t = t - {1'b0, divisor};
        q = {q[DVD_W-2:0], 1'b1};
      end else begin
        q = {q[DVD_W-2:0], 1'b0};
      end
      r = t[BIN_SZ_W-1:0];
    end
    rem_next = r;
    dvd_next = d;
    quo_next = q;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE: begin
        if (accept) state_next = F_DIV;
      end
      F_DIV: begin
        if (iter == ITER_W'(ITERS - 1)) state_next = F_PUSH;
      end
      F_PUSH: begin
        if (cmd_ready) state_next = F_IDLE;
      end
      default: state_next = F_IDLE;
    endcase
  end

  assign quo_ext = {{BIN_W{1'b0}}, quo};

  always_comb begin
    s_tready   = 1'b0;
    cmd_valid  = 1'b0;
    unique case (state)
      F_IDLE:  s_tready  = enable;
      F_DIV:   ;
      F_PUSH:  cmd_valid = 1'b1;
      default: ;
    endcase
    cmd.report = report;
    cmd.kernel = kernel;
    cmd.count  = tracked && (32'(quo) < 32'(MAX_BINS));
    cmd_bin    = quo_ext[BIN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= F_IDLE;
      epoch_length <= EPOCH_RESET;
      bin_size_mb  <= BIN_SZ_RESET;
      epoch_pos    <= '0;
      iter         <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_EPOCH_LENGTH: epoch_length <= cfg_data[EPOCH_W-1:0];
          CFG_BIN_SIZE_MB:  bin_size_mb  <= cfg_data[BIN_SZ_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        epoch_pos <= epoch_pos_next;
        iter      <= '0;
      end else if (state == F_DIV) begin
        iter <= iter + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      report  <= (epoch_pos == '0);
      kernel  <= s_tuser;
      tracked <= tracked_in;
      dvd     <= tracked_in ? DVD_W'(s_tdata[MB_SHIFT +: MIB_W]) : '0;
      quo     <= '0;
      rem     <= '0;
    end else if (state == F_DIV) begin
      dvd <= dvd_next;
      quo <= quo_next;
      rem <= rem_next;
    end
  end

endmodule

// ----- src/mabh_back.sv -----
module mabh_back #(
  parameter int MAX_BINS    = 64,
  parameter int COUNT_WIDTH = 24
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         q_valid,
  output logic                                         q_pop,
  input  mabh_pkg::cmd_t                               q_cmd,
  input  logic [((MAX_BINS > 1) ? $clog2(MAX_BINS) : 1)-1:0] q_bin,
  output logic                                         clearing,
  output logic                                         m_tvalid,
  input  logic                                         m_tready,
  output logic [mabh_pkg::OUT_DATA_W-1:0]              m_tdata,
  output logic                                         m_tlast
);

  import mabh_pkg::*;

  localparam int BIN_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int ENT_W = 2 * COUNT_WIDTH;
  localparam int PAD_W = OUT_DATA_W - OUT_BIN_W - 2 * OUT_CNT_W;
  localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(MAX_BINS - 1);

  back_state_t            state;
  back_state_t            state_next;
  logic [ENT_W-1:0]       mem [MAX_BINS];
  logic [ENT_W-1:0]       rd_data;
  logic                   rd_en;
  logic [BIN_W-1:0]       rd_addr;
  logic                   wr_en;
  logic [BIN_W-1:0]       wr_addr;
  logic [ENT_W-1:0]       wr_data;
  logic [BIN_W-1:0]       bin;
  cmd_t                   cmd;
  logic [BIN_W-1:0]       cmd_bin;
  logic [COUNT_WIDTH-1:0] rd_k;
  logic [COUNT_WIDTH-1:0] rd_u;
  logic                   nonzero;
  logic                   stall;
  logic                   out_free;
  logic                   bin_step;
  logic                   pend_load;
  logic                   pend_clear;
  logic                   pend_valid;
  logic [BIN_W-1:0]       pend_bin;
  logic [COUNT_WIDTH-1:0] pend_k;
  logic [COUNT_WIDTH-1:0] pend_u;
  logic                   push;
  logic                   push_last;
  logic [BIN_W-1:0]       push_bin;
  logic [COUNT_WIDTH-1:0] push_k;
  logic [COUNT_WIDTH-1:0] push_u;
  logic [BIN_W+OUT_BIN_W-1:0]       bin_ext;
  logic [COUNT_WIDTH+OUT_CNT_W-1:0] k_ext;
  logic [COUNT_WIDTH+OUT_CNT_W-1:0] u_ext;
  logic                   out_valid;
  logic                   out_last;
  logic [OUT_BIN_W-1:0]   out_bin;
  logic [OUT_CNT_W-1:0]   out_k;
  logic [OUT_CNT_W-1:0]   out_u;

  assign rd_k     = rd_data[ENT_W-1:COUNT_WIDTH];
  assign rd_u     = rd_data[COUNT_WIDTH-1:0];
  assign nonzero  = (rd_data != '0);
  assign out_free = !out_valid || m_tready;
  // a second nonzero bin waits until the held one can move on
  assign stall    = nonzero && pend_valid && !out_free;

  always_comb begin
    state_next = state;
    unique case (state)
      B_CLEAR: begin
        if (bin == LAST_BIN) state_next = B_IDLE;
      end
      B_IDLE: begin
        if (q_valid) begin
          if (q_cmd.report)     state_next = B_WALK_RD;
          else if (q_cmd.count) state_next = B_CNT_RD;
        end
      end
      B_WALK_RD: state_next = B_WALK_EV;
      B_WALK_EV: begin
        if (!stall) state_next = (bin == LAST_BIN) ? B_WALK_END : B_WALK_RD;
      end
      B_WALK_END: begin
        if (out_free) state_next = cmd.count ? B_CNT_RD : B_IDLE;
      end
      B_CNT_RD: state_next = B_CNT_WR;
      B_CNT_WR: state_next = B_IDLE;
      default:  state_next = B_IDLE;
    endcase
  end

  always_comb begin
    q_pop      = 1'b0;
    clearing   = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = bin;
    wr_en      = 1'b0;
    wr_addr    = bin;
    wr_data    = '0;
    bin_step   = 1'b0;
    pend_load  = 1'b0;
    pend_clear = 1'b0;
    push       = 1'b0;
    push_last  = 1'b0;
    push_bin   = pend_bin;
    push_k     = pend_k;
    push_u     = pend_u;
    unique case (state)
      B_CLEAR: begin
        clearing = 1'b1;
        wr_en    = 1'b1;
        bin_step = 1'b1;
      end
      B_IDLE: begin
        q_pop = q_valid;
      end
      B_WALK_RD: begin
        rd_en = 1'b1;
      end
      B_WALK_EV: begin
        if (!stall) begin
          wr_en     = 1'b1;
          bin_step  = 1'b1;
          pend_load = nonzero;
          push      = nonzero && pend_valid;
        end
      end
      B_WALK_END: begin
        if (out_free) begin
          push       = 1'b1;
          push_last  = 1'b1;
          pend_clear = 1'b1;
          if (!pend_valid) begin
            push_bin = '0;
            push_k   = '0;
            push_u   = '0;
          end
        end
      end
      B_CNT_RD: begin
        rd_en   = 1'b1;
        rd_addr = cmd_bin;
      end
      B_CNT_WR: begin
        wr_en   = 1'b1;
        wr_addr = cmd_bin;
        if (cmd.kernel) begin
          wr_data = {(&rd_k) ? rd_k : rd_k + 1'b1, rd_u};
        end else begin
          wr_data = {rd_k, (&rd_u) ? rd_u : rd_u + 1'b1};
        end
      end
      default: ;
    endcase
  end

  assign bin_ext = {{OUT_BIN_W{1'b0}}, push_bin};
  assign k_ext   = {{OUT_CNT_W{1'b0}}, push_k};
  assign u_ext   = {{OUT_CNT_W{1'b0}}, push_u};

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= B_CLEAR;
      bin        <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (bin_step) begin
        bin <= (bin == LAST_BIN) ? '0 : bin + 1'b1;
      end
      if (pend_load) begin
        pend_valid <= 1'b1;
      end else if (pend_clear) begin
        pend_valid <= 1'b0;
      end
      if (push) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd     <= q_cmd;
      cmd_bin <= q_bin;
    end
    if (pend_load) begin
      pend_bin <= bin;
      pend_k   <= rd_k;
      pend_u   <= rd_u;
    end
    if (push) begin
      out_last <= push_last;
      out_bin  <= bin_ext[OUT_BIN_W-1:0];
      out_k    <= k_ext[OUT_CNT_W-1:0];
      out_u    <= u_ext[OUT_CNT_W-1:0];
    end
  end

  assign m_tvalid = out_valid;
  assign m_tlast  = out_last;
  assign m_tdata  = {{PAD_W{1'b0}}, out_u, out_k, out_bin};

endmodule

// ----- src/memory_access_bin_histogram_unit.sv -----
// at defaults an access reaches the queue once the front divider has formed its bin, 4 bits at a time,
//   and the front has pushed it; a report's last beat, flagged by m_tlast, follows the walk of every bin
// the front takes no new access until it has pushed the last one; a report holds the back while it
//   walks the bins, so once 4 accesses are queued and a fifth waits in the front s_tready stays low until a slot frees
// reset: synchronous rst; the back then zeroes all MAX_BINS bins of the histogram memory
//   (64 at defaults) with s_tready low; configuration returns to its reset values
`include "assert_macros.svh"

module memory_access_bin_histogram_unit #(
  parameter int MAX_BINS    = 64,
  parameter int COUNT_WIDTH = 24,
  parameter int TRACKED_MB  = 1024
) (
  input  logic                               clk,
  input  logic                               rst,
  // configuration writes
  input  logic                               cfg_we,
  input  logic [mabh_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mabh_pkg::CFG_W-1:0]         cfg_data,
  // access beats
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [mabh_pkg::ADDR_W-1:0]        s_tdata,   // address[31:0]
  input  logic                               s_tuser,   // kernel_mode
  // report beats
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [mabh_pkg::OUT_DATA_W-1:0]    m_tdata,   // bin_index[5:0], kernel_count[29:6],
                                                        // user_count[53:30], zero pad
  output logic                               m_tlast    // last
);

  import mabh_pkg::*;

  localparam int BIN_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int CMD_W = $bits(cmd_t);
  localparam int Q_W   = CMD_W + BIN_W;
  localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);

  // front side: epoch tracking and bin computation
  logic              f_valid;
  logic              f_ready;
  cmd_t              f_cmd;
  logic [BIN_W-1:0]  f_bin;
  // queue between the two halves
  logic [Q_W-1:0]    q_in;
  logic [Q_W-1:0]    q_out;
  logic              q_valid;
  logic              q_pop;
  logic [LVL_W-1:0]  q_level;
  // back side status
  logic              clearing;
  // both count fields of the outgoing beat
  logic [2*OUT_CNT_W-1:0] beat_counts;

  mabh_front #(
    .MAX_BINS   (MAX_BINS),
    .TRACKED_MB (TRACKED_MB)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .enable    (!clearing),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd       (f_cmd),
    .cmd_bin   (f_bin)
  );

  assign q_in = {f_cmd, f_bin};

  // a short queue lets the front keep taking accesses during a report walk
  mabh_queue #(
    .WIDTH (Q_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (q_in),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_data   (q_out),
    .level      (q_level)
  );

  // back side: histogram memory, report walk and output register
  mabh_back #(
    .MAX_BINS    (MAX_BINS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_cmd    (cmd_t'(q_out[Q_W-1:BIN_W])),
    .q_bin    (q_out[BIN_W-1:0]),
    .clearing (clearing),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  assign beat_counts = m_tdata[OUT_BIN_W+2*OUT_CNT_W-1:OUT_BIN_W];

  // no access enters while the memory is still being zeroed
  `CHK_IMPLY(a_no_accept_while_clearing, clearing, !s_tready, "access taken during clear pass")
  // only the closing beat of a report may carry all-zero counts
  `CHK_IMPLY(a_nonlast_nonzero, m_tvalid && !m_tlast, beat_counts != '0, "empty bin mid-report")
  // queue fill never passes its depth
  `CHK_ALWAYS(a_queue_bound, q_level <= LVL_W'(QUEUE_DEPTH), "queue over depth")

endmodule
